/* design/wts_pkg.sv */
// Shared constants and codes for the world-to-screen projection core.
`default_nettype none
package wts_pkg;
   localparam int COEF_WIDTH      = 32;
   localparam int MATRIX_ENTRIES  = 16;
   localparam int INDEX_WIDTH     = 4;
   localparam int SIZE_WIDTH      = 14;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_POINT = 1'b1;
   localparam logic MAT_VIEW = 1'b0;
   localparam logic MAT_PROJ = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 4'd1;

   localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RESET  = 14'd1920;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RESET = 14'd1080;
endpackage
`default_nettype wire

/* design/wts_if.sv */
// Channel interfaces: point/coefficient requests, screen results, register writes.
`default_nettype none
interface wts_req_if #(parameter int COORD_WIDTH = 32);
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic                                 matrix_select;
   logic [wts_pkg::INDEX_WIDTH-1:0]      coefficient_index;
   logic signed [wts_pkg::COEF_WIDTH-1:0] coefficient_value;
   logic signed [COORD_WIDTH-1:0]        point_x;
   logic signed [COORD_WIDTH-1:0]        point_y;
   logic signed [COORD_WIDTH-1:0]        point_z;

   modport source (output valid, op, matrix_select, coefficient_index, coefficient_value,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, op, matrix_select, coefficient_index, coefficient_value,
                   point_x, point_y, point_z, output ready);
endinterface

interface wts_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic                          in_front;
   logic signed [COORD_WIDTH-1:0] screen_x;
   logic signed [COORD_WIDTH-1:0] screen_y;

   modport source (output valid, in_front, screen_x, screen_y, input ready);
   modport sink   (input valid, in_front, screen_x, screen_y, output ready);
endinterface

interface wts_csr_if;
   logic                                valid;
   logic                                ready;
   logic [wts_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [wts_pkg::SIZE_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/world_to_screen_projection_core.sv */
// Top level: pipelined world-to-screen vertex transform with viewport mapping.
`default_nettype none
// One request beat per cycle while the pipeline is not held. A point beat runs through the view
// matrix product (products, then sum and round), the projection product
// (rows 0, 1 and 3), a clip-w check, the viewport scale multiply and a
// restoring divider with one quotient bit per stage, in COORD_WIDTH + 2
// divider stages (an overflow check, then one stage per quotient bit). A
// coefficient beat also takes one slot: a view entry is written as the beat
// is accepted, a projection entry as the beat passes the projection
// multiply, so every point sees exactly the matrices written before it.
// Coefficient beats give no result beat. The whole pipeline advances
// together; it holds only while a result beat sits in the output register
// and the sink is not ready. Points with clip w at or below 0.001 come out
// with in_front low and zero coordinates. Screen size registers are written
// on the csr channel, which is always ready.
module world_to_screen_projection_core #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   wts_req_if.sink       req_bus,
   wts_rsp_if.source     rsp_bus,
   wts_csr_if.sink       csr_bus
);
   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + wts_pkg::COEF_WIDTH;       // one product
   localparam int SW = PW + 2;                          // sum of four products
   localparam int QB = CW + 1;                          // quotient bits
   localparam int DB = CW;                              // divisor bits
   localparam int SB = wts_pkg::SIZE_WIDTH + FRAC_BITS; // scaled screen size
   localparam int NB = QB + SB;                         // dividend bits
   localparam int CB = (SB > DB) ? SB : DB;             // overflow compare width

   localparam logic signed [CW-1:0] W_MIN      = CW'((64'd1 << FRAC_BITS) / 1000);
   localparam logic signed [CW-1:0] COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam logic [QB:0]          HALF_RANGE = (QB+1)'(1) << (CW-1);

   typedef struct packed {
      logic [DB-1:0] rem;
      logic [QB-1:0] low;
      logic [QB-1:0] q;
      logic          ov;
      logic          neg;
   } lane_type;

   typedef struct packed {
      logic          valid;
      logic          front;
      logic [DB-1:0] d;
      lane_type      x;
      lane_type      y;
   } div_type;

   // shift out the fraction and clamp to the coordinate range
   function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] a);
      logic signed [SW-1:0] s;
      logic [SW-CW:0]       hi;
      s  = a >>> FRAC_BITS;
      hi = s[SW-1:CW-1];
      if (hi == '0 || hi == '1) begin
         return s[CW-1:0];
      end else if (s[SW-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   function automatic lane_type div_step(input lane_type l, input logic [DB-1:0] d);
      lane_type    r;
      logic [DB:0] t;
      logic        qbit;
      t    = {l.rem, l.low[QB-1]};
      qbit = (t >= {1'b0, d});
      r    = l;
      if (qbit) begin
         r.rem = DB'(t - {1'b0, d});
      end else begin
         r.rem = t[DB-1:0];
      end
      r.low = {l.low[QB-2:0], 1'b0};
      r.q   = {l.q[QB-2:0], qbit};
      return r;
   endfunction

   function automatic lane_type div_init(input logic [NB-1:0] n, input logic [DB-1:0] d,
                                         input logic neg);
      lane_type      r;
      logic [CB-1:0] top;
      top   = CB'(n[NB-1:QB]);
      r.ov  = (top >= CB'(d));
      r.rem = top[DB-1:0];
      r.low = n[QB-1:0];
      r.q   = '0;
      r.neg = neg;
      return r;
   endfunction

   // floor of the signed quotient, clamped
   function automatic logic signed [CW-1:0] div_finish(input lane_type l);
      logic [QB:0] m;
      m = {1'b0, l.q} + (QB+1)'(l.neg && (l.rem != '0));
      if (l.ov) begin
         return l.neg ? COORD_MIN : COORD_MAX;
      end else if (l.neg) begin
         return (m > HALF_RANGE) ? COORD_MIN : -$signed(m[CW-1:0]);
      end else begin
         return (m >= HALF_RANGE) ? COORD_MAX : $signed(m[CW-1:0]);
      end
   endfunction

   // ---------------------------------------------------------------- control
   logic en;
   logic req_accept;
   logic rsp_valid_ff;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;
   assign req_accept    = req_bus.valid && en;

   // ---------------------------------------------------------------- registers
   logic [wts_pkg::SIZE_WIDTH-1:0] width_ff;
   logic [wts_pkg::SIZE_WIDTH-1:0] height_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= wts_pkg::SCREEN_WIDTH_RESET;
         height_ff <= wts_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            wts_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_bus.data;
            wts_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_bus.data;
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   // ---------------------------------------------------------------- matrices
   logic signed [wts_pkg::COEF_WIDTH-1:0] view_ff [wts_pkg::MATRIX_ENTRIES];
   logic signed [wts_pkg::COEF_WIDTH-1:0] proj_ff [wts_pkg::MATRIX_ENTRIES];

   logic                                  s2_valid_ff, s2_point_ff, s2_sel_ff;
   logic [wts_pkg::INDEX_WIDTH-1:0]       s2_idx_ff;
   logic signed [wts_pkg::COEF_WIDTH-1:0] s2_val_ff;

   // view entries land at accept, projection entries when the beat reaches
   // the projection multiply; both keep program order against points
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wts_pkg::MATRIX_ENTRIES; i++) begin
            view_ff[i] <= '0;
            proj_ff[i] <= '0;
         end
      end else begin
         if (req_accept && req_bus.op == wts_pkg::OP_WRITE &&
             req_bus.matrix_select == wts_pkg::MAT_VIEW) begin
            view_ff[req_bus.coefficient_index] <= req_bus.coefficient_value;
         end
         if (en && s2_valid_ff && !s2_point_ff && s2_sel_ff == wts_pkg::MAT_PROJ) begin
            proj_ff[s2_idx_ff] <= s2_val_ff;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1: view products
   logic                                  s1_valid_ff, s1_point_ff, s1_sel_ff;
   logic [wts_pkg::INDEX_WIDTH-1:0]       s1_idx_ff;
   logic signed [wts_pkg::COEF_WIDTH-1:0] s1_val_ff;
   logic signed [PW-1:0]                  vp_ff [4][3];
   logic signed [PW-1:0]                  vp_in [4][3];
   logic signed [wts_pkg::COEF_WIDTH-1:0] vt_ff [4];
   logic signed [CW-1:0]                  pt [3];

   always_comb begin
      pt[0] = req_bus.point_x;
      pt[1] = req_bus.point_y;
      pt[2] = req_bus.point_z;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            vp_in[r][c] = PW'(view_ff[4*r+c]) * PW'(pt[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_point_ff <= req_bus.op == wts_pkg::OP_POINT;
         s1_sel_ff   <= req_bus.matrix_select;
         s1_idx_ff   <= req_bus.coefficient_index;
         s1_val_ff   <= req_bus.coefficient_value;
         vp_ff       <= vp_in;
         for (int r = 0; r < 4; r++) begin
            vt_ff[r] <= view_ff[4*r+3];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2: view coordinates
   logic signed [CW-1:0] vc_ff [4];
   logic signed [CW-1:0] vc_in [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         vc_in[r] = round_sat(SW'(vp_ff[r][0]) + SW'(vp_ff[r][1]) + SW'(vp_ff[r][2]) +
                              (SW'(vt_ff[r]) <<< FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_point_ff <= s1_point_ff;
         s2_sel_ff   <= s1_sel_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_val_ff   <= s1_val_ff;
         vc_ff       <= vc_in;
      end
   end

   // ---------------------------------------------------------------- stage 3: projection products
   // lanes 0, 1, 2 use projection rows 0, 1, 3; coefficient beats drop here
   logic                 s3_valid_ff;
   logic signed [PW-1:0] pp_ff [3][4];
   logic signed [PW-1:0] pp_in [3][4];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            pp_in[r][c] = PW'(proj_ff[((r == 2) ? 12 : 4*r) + c]) * PW'(vc_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff && s2_point_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: clip coordinates
   logic                 s4_valid_ff, s4_front_ff;
   logic signed [CW-1:0] pc_ff [3];
   logic signed [CW-1:0] pc_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         pc_in[r] = round_sat(SW'(pp_ff[r][0]) + SW'(pp_ff[r][1]) +
                              SW'(pp_ff[r][2]) + SW'(pp_ff[r][3]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff       <= pc_in;
         s4_front_ff <= pc_in[2] > W_MIN;
      end
   end

   // ---------------------------------------------------------------- stage 5: numerator magnitudes
   logic                  s5_valid_ff, s5_front_ff;
   logic [QB-1:0]         s5_mag_x_ff, s5_mag_y_ff;
   logic                  s5_neg_x_ff, s5_neg_y_ff;
   logic [DB-1:0]         s5_d_ff;
   logic signed [CW:0]    nx, ny;

   assign nx = {pc_ff[0][CW-1], pc_ff[0]} + {pc_ff[2][CW-1], pc_ff[2]};
   assign ny = {pc_ff[2][CW-1], pc_ff[2]} - {pc_ff[1][CW-1], pc_ff[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_front_ff <= s4_front_ff;
         s5_neg_x_ff <= nx[CW];
         s5_neg_y_ff <= ny[CW];
         s5_mag_x_ff <= nx[CW] ? QB'(-nx) : QB'(nx);
         s5_mag_y_ff <= ny[CW] ? QB'(-ny) : QB'(ny);
         s5_d_ff     <= {pc_ff[2][CW-2:0], 1'b0};
      end
   end

   // ---------------------------------------------------------------- stage 6: scale by screen size
   logic          s6_valid_ff, s6_front_ff;
   logic [NB-1:0] s6_n_x_ff, s6_n_y_ff;
   logic          s6_neg_x_ff, s6_neg_y_ff;
   logic [DB-1:0] s6_d_ff;
   logic [SB-1:0] scale_x, scale_y;

   assign scale_x = {width_ff, {FRAC_BITS{1'b0}}};
   assign scale_y = {height_ff, {FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_front_ff <= s5_front_ff;
         s6_neg_x_ff <= s5_neg_x_ff;
         s6_neg_y_ff <= s5_neg_y_ff;
         s6_d_ff     <= s5_d_ff;
         s6_n_x_ff   <= NB'(s5_mag_x_ff) * NB'(scale_x);
         s6_n_y_ff   <= NB'(s5_mag_y_ff) * NB'(scale_y);
      end
   end

   // ---------------------------------------------------------------- divider stages
   // entry 0 checks for quotient overflow, entries 1..QB each retire one bit
   div_type dv_ff [QB+1];
   div_type dv_in [QB+1];

   always_comb begin
      dv_in[0].valid = s6_valid_ff;
      dv_in[0].front = s6_front_ff;
      dv_in[0].d     = s6_d_ff;
      dv_in[0].x     = div_init(s6_n_x_ff, s6_d_ff, s6_neg_x_ff);
      dv_in[0].y     = div_init(s6_n_y_ff, s6_d_ff, s6_neg_y_ff);
      for (int k = 1; k <= QB; k++) begin
         dv_in[k]   = dv_ff[k-1];
         dv_in[k].x = div_step(dv_ff[k-1].x, dv_ff[k-1].d);
         dv_in[k].y = div_step(dv_ff[k-1].y, dv_ff[k-1].d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         dv_ff <= dv_in;
      end
   end

   // ---------------------------------------------------------------- output register
   logic                 rsp_front_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_front_ff <= dv_ff[QB].front;
         rsp_x_ff     <= dv_ff[QB].front ? div_finish(dv_ff[QB].x) : '0;
         rsp_y_ff     <= dv_ff[QB].front ? div_finish(dv_ff[QB].y) : '0;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.in_front = rsp_front_ff;
   assign rsp_bus.screen_x = rsp_x_ff;
   assign rsp_bus.screen_y = rsp_y_ff;

   // ---------------------------------------------------------------- assertions
   a_behind_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.in_front |-> rsp_bus.screen_x == '0 && rsp_bus.screen_y == '0)
      else $error("behind-camera result beat carries nonzero coordinates");

   a_height_write_keeps_width: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid && csr_bus.ready && csr_bus.index == wts_pkg::CSR_SCREEN_HEIGHT
      |=> $stable(width_ff))
      else $error("screen height write disturbed screen width");

   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(rsp_x_ff) && $stable(rsp_y_ff) && $stable(dv_ff[QB].valid))
      else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

/* test/world_to_screen_projection_core_tb.sv */
// Testbench for the world-to-screen projection core: random and directed beats, scoreboarded.
`timescale 1ns / 1ps
module world_to_screen_projection_core_tb;
   localparam int FRAC        = 16;
   localparam int CW          = 32;
   localparam int LATENCY     = CW + 9;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ONE         = 65536;
   localparam logic signed [127:0] COORD_MAX = 128'sh7FFFFFFF;
   localparam logic signed [127:0] COORD_MIN = -128'sh80000000;
   localparam logic signed [31:0]  W_FLOOR   = 32'sd65;   // floor(2^16 / 1000)
   // an index with no register behind it
   localparam logic [wts_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 4'd7;

   typedef logic signed [31:0] coef_bank_type [wts_pkg::MATRIX_ENTRIES];

   typedef struct {
      logic                                  op;
      logic                                  matrix_select;
      logic [wts_pkg::INDEX_WIDTH-1:0]       coefficient_index;
      logic signed [wts_pkg::COEF_WIDTH-1:0] coefficient_value;
      logic signed [CW-1:0]                  point_x;
      logic signed [CW-1:0]                  point_y;
      logic signed [CW-1:0]                  point_z;
   } vertex_beat_type;

   typedef struct {
      logic                 in_front;
      logic signed [CW-1:0] screen_x;
      logic signed [CW-1:0] screen_y;
   } screen_pos_type;

   logic clock;
   logic reset;

   wts_req_if #(.COORD_WIDTH(CW)) req_bus ();
   wts_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();
   wts_csr_if                     csr_bus ();

   world_to_screen_projection_core #(.FRAC_BITS(FRAC), .COORD_WIDTH(CW)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow state of the block
   coef_bank_type                  view_bank;
   coef_bank_type                  proj_bank;
   logic [wts_pkg::SIZE_WIDTH-1:0] width_shadow;
   logic [wts_pkg::SIZE_WIDTH-1:0] height_shadow;

   vertex_beat_type vertex_queue[$];     // beats waiting to be driven
   screen_pos_type  screen_expect[$];    // predicted screen positions, oldest first

   int fail_count;
   int screens_checked;
   int behind_count;
   int cycle_count;

   // Sender burst shaping
   int burst_left;
   int gap_left;

   // Receiver stall shaping
   int  ready_mode;
   int  mode_left;
   int  long_stall_left;
   bit  long_stall_done;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Saturate a wide signed value to the coordinate range.
   function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v);
      if (v > COORD_MAX) return COORD_MAX[CW-1:0];
      if (v < COORD_MIN) return COORD_MIN[CW-1:0];
      return v[CW-1:0];
   endfunction

   // One matrix row times a column vector, floor-shifted and saturated.
   function automatic logic signed [CW-1:0] row_times_vec(coef_bank_type m, int base,
         logic signed [CW-1:0] a, logic signed [CW-1:0] b,
         logic signed [CW-1:0] c, logic signed [CW-1:0] d);
      logic signed [127:0] acc;
      acc = m[base] * a;
      acc = acc + m[base+1] * b;
      acc = acc + m[base+2] * c;
      acc = acc + m[base+3] * d;
      return clamp_coord(acc >>> FRAC);
   endfunction

   // floor((offset) * size * 2^FRAC / (2 w)), saturated
   function automatic logic signed [CW-1:0] viewport_map(logic signed [127:0] offset,
         logic [wts_pkg::SIZE_WIDTH-1:0] size, logic signed [CW-1:0] w);
      logic signed [127:0] scale;
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] q;
      scale = 128'(size);
      scale = scale <<< FRAC;
      num   = offset * scale;
      den   = w;
      den   = den * 2;
      q     = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return clamp_coord(q);
   endfunction

   // Apply one accepted beat to the shadow state; queue the screen position of a point.
   function automatic void project_vertex(vertex_beat_type vb);
      logic signed [CW-1:0] one_fx;
      logic signed [CW-1:0] vx, vy, vz, vw, clip_x, clip_y, clip_w;
      logic signed [127:0]  offs;
      screen_pos_type       sp;
      if (vb.op == wts_pkg::OP_WRITE) begin
         if (vb.matrix_select == wts_pkg::MAT_PROJ)
            proj_bank[vb.coefficient_index] = vb.coefficient_value;
         else view_bank[vb.coefficient_index] = vb.coefficient_value;
         return;
      end
      one_fx = ONE;
      vx = row_times_vec(view_bank, 0,  vb.point_x, vb.point_y, vb.point_z, one_fx);
      vy = row_times_vec(view_bank, 4,  vb.point_x, vb.point_y, vb.point_z, one_fx);
      vz = row_times_vec(view_bank, 8,  vb.point_x, vb.point_y, vb.point_z, one_fx);
      vw = row_times_vec(view_bank, 12, vb.point_x, vb.point_y, vb.point_z, one_fx);
      clip_x = row_times_vec(proj_bank, 0,  vx, vy, vz, vw);
      clip_y = row_times_vec(proj_bank, 4,  vx, vy, vz, vw);
      clip_w = row_times_vec(proj_bank, 12, vx, vy, vz, vw);
      if (clip_w <= W_FLOOR) begin
         sp.in_front = 1'b0;
         sp.screen_x = '0;
         sp.screen_y = '0;
      end else begin
         sp.in_front = 1'b1;
         offs = clip_x;
         offs = offs + clip_w;
         sp.screen_x = viewport_map(offs, width_shadow, clip_w);
         offs = clip_w;
         offs = offs - clip_y;
         sp.screen_y = viewport_map(offs, height_shadow, clip_w);
      end
      screen_expect.push_back(sp);
   endfunction

   function automatic int rand_span(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic void push_coef(logic sel, int idx, int val);
      vertex_beat_type vb;
      vb.op                = wts_pkg::OP_WRITE;
      vb.matrix_select     = sel;
      vb.coefficient_index = idx[wts_pkg::INDEX_WIDTH-1:0];
      vb.coefficient_value = val;
      vb.point_x           = $urandom;
      vb.point_y           = $urandom;
      vb.point_z           = $urandom;
      vertex_queue.push_back(vb);
   endfunction

   function automatic void push_point(int x, int y, int z);
      vertex_beat_type vb;
      vb.op                = wts_pkg::OP_POINT;
      vb.matrix_select     = 1'($urandom_range(0, 1));
      vb.coefficient_index = wts_pkg::INDEX_WIDTH'($urandom);
      vb.coefficient_value = $urandom;
      vb.point_x           = x;
      vb.point_y           = y;
      vb.point_z           = z;
      vertex_queue.push_back(vb);
   endfunction

   // Load a plausible camera: near-identity view with translation, w taken from view z.
   function automatic void load_camera();
      int v;
      int focal;
      focal = ONE * rand_span(1, 3) + rand_span(-8192, 8192);
      for (int i = 0; i < wts_pkg::MATRIX_ENTRIES; i++) begin
         v = 0;
         if (i / 4 == i % 4) v = ONE + rand_span(-4096, 4096);
         if (i % 4 == 3 && i < 12) v = rand_span(-1048576, 1048576);
         if (i == 15) v = ONE;
         push_coef(wts_pkg::MAT_VIEW, i, v);
      end
      for (int i = 0; i < wts_pkg::MATRIX_ENTRIES; i++) begin
         v = 0;
         if (i == 0 || i == 5) v = focal;
         if (i / 4 == 2) v = $urandom;      // row 2 is never used
         if (i == 14) v = ONE;
         push_coef(wts_pkg::MAT_PROJ, i, v);
      end
   endfunction

   // Mostly sensible points under the loaded camera, mixed with noise.
   function automatic void push_random_mix(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) load_camera();
         else if (pick < 11) push_coef(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                       $urandom);
         else if (pick < 19) push_point($urandom, $urandom, $urandom);
         else if (pick < 25) push_point(rand_span(-1048576, 1048576),
                                        rand_span(-1048576, 1048576), rand_span(-200, 200));
         else push_point(rand_span(-1048576, 1048576), rand_span(-1048576, 1048576),
                         rand_span(-524288, 2097152));
      end
   endfunction

   // Hold until every beat is accepted and every result is back, then let the pipe empty.
   task automatic wait_drained();
      while (vertex_queue.size() != 0 || req_bus.valid || screen_expect.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_csr(logic [wts_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [wts_pkg::SIZE_WIDTH-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == wts_pkg::CSR_SCREEN_WIDTH) width_shadow = val;
      else if (idx == wts_pkg::CSR_SCREEN_HEIGHT) height_shadow = val;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_screen(logic [wts_pkg::SIZE_WIDTH-1:0] w,
                             logic [wts_pkg::SIZE_WIDTH-1:0] h);
      write_csr(wts_pkg::CSR_SCREEN_WIDTH, w);
      write_csr(wts_pkg::CSR_SCREEN_HEIGHT, h);
   endtask

   // Driver: bursts with random gaps; predict each beat as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 0;
         gap_left      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            project_vertex('{req_bus.op, req_bus.matrix_select, req_bus.coefficient_index,
                             req_bus.coefficient_value, req_bus.point_x, req_bus.point_y,
                             req_bus.point_z});
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (vertex_queue.size() != 0) begin
               vertex_beat_type vb;
               vb = vertex_queue.pop_front();
               req_bus.valid             <= 1'b1;
               req_bus.op                <= vb.op;
               req_bus.matrix_select     <= vb.matrix_select;
               req_bus.coefficient_index <= vb.coefficient_index;
               req_bus.coefficient_value <= vb.coefficient_value;
               req_bus.point_x           <= vb.point_x;
               req_bus.point_y           <= vb.point_y;
               req_bus.point_z           <= vb.point_z;
               if (burst_left <= 1) begin
                  // end of burst: pick the next burst and the gap that follows it
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes every so often, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         ready_mode      <= 0;
         mode_left       <= 0;
         long_stall_left <= 0;
         long_stall_done <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (screen_expect.size() == 0) begin
               $error("result beat with no prediction waiting");
               fail_count++;
            end else begin
               screen_pos_type sp;
               sp = screen_expect.pop_front();
               if (rsp_bus.in_front !== sp.in_front) begin
                  $error("in_front: expected %0d, got %0d", sp.in_front, rsp_bus.in_front);
                  fail_count++;
               end
               if (rsp_bus.screen_x !== sp.screen_x) begin
                  $error("screen_x: expected %0d, got %0d", sp.screen_x, rsp_bus.screen_x);
                  fail_count++;
               end
               if (rsp_bus.screen_y !== sp.screen_y) begin
                  $error("screen_y: expected %0d, got %0d", sp.screen_y, rsp_bus.screen_y);
                  fail_count++;
               end
               if (!sp.in_front) behind_count++;
            end
            screens_checked++;
         end

         if (!long_stall_done && screens_checked >= 300) begin
            // hold off long enough that the pipeline fills and backs up the request side
            long_stall_done <= 1'b1;
            long_stall_left <= 4 * LATENCY;
            rsp_bus.ready   <= 1'b0;
         end else if (long_stall_left > 0) begin
            long_stall_left <= long_stall_left - 1;
            rsp_bus.ready   <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode <= $urandom_range(0, 2);
               mode_left  <= $urandom_range(16, 96);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (ready_mode)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      cycle_count     = 0;
      fail_count      = 0;
      screens_checked = 0;
      behind_count    = 0;
      req_bus.valid             = 1'b0;
      req_bus.op                = wts_pkg::OP_WRITE;
      req_bus.matrix_select     = wts_pkg::MAT_VIEW;
      req_bus.coefficient_index = '0;
      req_bus.coefficient_value = '0;
      req_bus.point_x           = '0;
      req_bus.point_y           = '0;
      req_bus.point_z           = '0;
      rsp_bus.ready             = 1'b0;
      csr_bus.valid             = 1'b0;
      csr_bus.index             = '0;
      csr_bus.data              = '0;
      for (int i = 0; i < wts_pkg::MATRIX_ENTRIES; i++) begin
         view_bank[i] = '0;
         proj_bank[i] = '0;
      end
      width_shadow  = wts_pkg::SCREEN_WIDTH_RESET;
      height_shadow = wts_pkg::SCREEN_HEIGHT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset sizes, point against all-zero matrices, then a unit camera.
      push_point(0, 0, 0);
      for (int i = 0; i < wts_pkg::MATRIX_ENTRIES; i++) begin
         push_coef(wts_pkg::MAT_VIEW, i, (i / 4 == i % 4) ? ONE : 0);
         push_coef(wts_pkg::MAT_PROJ, i, (i == 0 || i == 5 || i == 14) ? ONE : 0);
      end
      push_point(0, 0, ONE);                         // screen center
      push_point(0, 0, 65);                          // w exactly at threshold: behind
      push_point(0, 0, 66);                          // just above threshold
      push_point(ONE, -ONE, -ONE);                   // negative w: behind
      push_point(32'h7FFFFFFF, 32'h7FFFFFFF, 66);    // saturating
      push_point(32'h80000000, 32'h80000000, 66);
      push_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      push_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      push_coef(wts_pkg::MAT_VIEW, 15, 32'h7FFFFFFF);   // extreme coefficients
      push_coef(wts_pkg::MAT_PROJ, 0, 32'h80000000);
      push_point(ONE, ONE, ONE);
      push_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      wait_drained();

      // Sender pause above lets every result come back; now sweep screen sizes.
      set_screen(14'd8192, 14'd8192);
      write_csr(CSR_UNUSED, 14'h3FFF);                // unknown index, ignored
      load_camera();
      push_random_mix(90);
      wait_drained();

      set_screen(14'd1, 14'd1);
      load_camera();
      push_random_mix(90);
      wait_drained();

      set_screen(14'h3FFF, 14'd0);                    // out of range, used as given
      load_camera();
      push_random_mix(70);
      wait_drained();

      set_screen(wts_pkg::SIZE_WIDTH'(rand_span(1, 8192)),
                 wts_pkg::SIZE_WIDTH'(rand_span(1, 8192)));
      load_camera();
      push_random_mix(90);
      wait_drained();

      set_screen(14'd0, 14'h2AAA);
      load_camera();
      push_random_mix(50);
      wait_drained();

      $display("Checked %0d screen results (%0d behind the camera) over six size settings,",
               screens_checked, behind_count);
      $display("with bursty requests, random result stalls and one long result hold-off.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* world_to_screen_projection_core.f */
design/wts_pkg.sv
design/wts_if.sv
design/world_to_screen_projection_core.sv
test/world_to_screen_projection_core_tb.sv
